// ----- sv/lphm_pkg.sv -----
package lphm_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int HASH_W = 32;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int EXT_W  = 32;
    localparam int IDXF_W = 7;
    localparam int STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_SET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_END       = 3'd6
    } status_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [EXT_W-1:0]  extra;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_HASH,
        S_CHECK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic mod_start;
        logic load_start;
        logic load_hash;
        logic step;
        logic finish_early;
        logic finish_probe;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_next;
        logic start_oob;
        logic hash_zero;
        logic mod_done;
        logic hit;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- sv/lphm_mod.sv -----
module lphm_mod import lphm_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [HASH_W-1:0]          din,
    output logic                       done,
    output logic [$clog2(SLOTS)-1:0]   rem
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;

    logic             done_reg;
    logic [IDX_W-1:0] rem_reg;

    assign done = done_reg;
    assign rem  = rem_reg;

    if (POW2) begin : g_mask
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                done_reg <= 1'b0;
            end else begin
                done_reg <= start;
            end
        end

        always_ff @(posedge aclk) begin
            if (start) begin
                rem_reg <= din[IDX_W-1:0];
            end
        end
    end else begin : g_recip
        // quotient by reciprocal multiplication (exact for any 32-bit hash);
        // the remainder fits in IDX_W bits, so only the low bits of the
        // quotient and the hash enter din - q * SLOTS
        localparam int PROD_W = 2 * HASH_W + 1;
        localparam longint unsigned RECIP_L =
            ((64'd1 << (HASH_W + IDX_W)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
        localparam logic [HASH_W:0]  RECIP    = (HASH_W + 1)'(RECIP_L);
        localparam logic [IDX_W-1:0] SLOTS_LO = IDX_W'(SLOTS);

        logic                stage_reg;
        logic [PROD_W-1:0]   prod;
        logic [IDX_W-1:0]    q_lo_reg;
        logic [IDX_W-1:0]    h_lo_reg;
        logic [2*IDX_W-1:0]  qs;

        assign prod = PROD_W'(din) * PROD_W'(RECIP);
        assign qs   = (2*IDX_W)'(q_lo_reg) * (2*IDX_W)'(SLOTS_LO);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg <= 1'b0;
                done_reg  <= 1'b0;
            end else begin
                stage_reg <= start;
                done_reg  <= stage_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (start) begin
                q_lo_reg <= prod[HASH_W+IDX_W +: IDX_W];
                h_lo_reg <= din[IDX_W-1:0];
            end
            if (stage_reg) begin
                rem_reg <= h_lo_reg - qs[IDX_W-1:0];
            end
        end
    end

endmodule

// ----- sv/lphm_datapath.sv -----
module lphm_datapath import lphm_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [HASH_W-1:0] s_key_hash,
    input  logic [KEY_W-1:0]  s_key_word,
    input  logic [VAL_W-1:0]  s_new_value,
    input  logic [EXT_W-1:0]  s_new_extra,
    input  logic [IDXF_W-1:0] s_start_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [VAL_W-1:0]  m_out_value,
    output logic [EXT_W-1:0]  m_out_extra,
    output logic [KEY_W-1:0]  m_out_key,
    output logic [HASH_W-1:0] m_out_hash,
    output logic [IDXF_W-1:0] m_slot_index
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (IDX_W + 1 > IDXF_W) ? IDX_W + 1 : IDXF_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    // latched request
    cmd_t              cmd_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [EXT_W-1:0]  extra_reg;
    logic [IDXF_W-1:0] start_reg;

    // probe state
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  lim_m1;
    logic [IDX_W:0]    idx_plus1;
    logic [CMP_W-1:0]  start_ext;

    // storage
    entry_t            slot_mem [SLOTS];
    entry_t            rd_data_reg;
    entry_t            wr_data;
    logic              wr_en;

    logic              mod_done;
    logic [IDX_W-1:0]  mod_rem;

    logic              occupied, match, hit, last, finish;

    // result
    status_t           res_status;
    logic [VAL_W-1:0]  res_value;
    logic [EXT_W-1:0]  res_extra;
    logic [KEY_W-1:0]  res_key;
    logic [HASH_W-1:0] res_hash;
    logic [IDXF_W-1:0] res_idx;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [VAL_W-1:0]  m_value_reg;
    logic [EXT_W-1:0]  m_extra_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic [HASH_W-1:0] m_hash_reg;
    logic [IDXF_W-1:0] m_idx_reg;

    lphm_mod #(.SLOTS(SLOTS)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .din     (hash_reg),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg   <= cmd_t'(s_cmd);
            hash_reg  <= s_key_hash;
            key_reg   <= s_key_word;
            value_reg <= s_new_value;
            extra_reg <= s_new_extra;
            start_reg <= s_start_slot;
        end
    end

    assign start_ext = CMP_W'(start_reg);
    assign idx_plus1 = {1'b0, idx_reg} + 1'b1;
    assign lim_m1    = (used_reg == FULL_CNT) ? LAST_IDX : used_reg[IDX_W-1:0];

    always_comb begin
        idx_next       = idx_reg;
        probe_cnt_next = probe_cnt_reg;
        if (cmd.clear_wr || cmd.step) begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
        if (cmd.step) begin
            probe_cnt_next = probe_cnt_reg + 1'b1;
        end
        if (cmd.load_start) begin
            idx_next       = IDX_W'(start_ext);
            probe_cnt_next = '0;
        end
        if (cmd.load_hash) begin
            idx_next       = mod_rem;
            probe_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            used_reg <= '0;
        end else begin
            idx_reg  <= idx_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_cnt_reg <= probe_cnt_next;
    end

    // read follows the index the probe moves to, so rd_data_reg holds the entry at
    // idx_reg; a write to that slot shows there only once the slot is read again
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= slot_mem[idx_next];
    end

    assign occupied = rd_data_reg.hash != '0;
    assign match    = (rd_data_reg.hash == hash_reg) && (rd_data_reg.key == key_reg);

    always_comb begin
        case (cmd_reg)
            CMD_NEXT: begin
                hit  = occupied;
                last = idx_reg == LAST_IDX;
            end
            CMD_SET: begin
                hit  = !occupied || match;
                last = probe_cnt_reg == lim_m1;
            end
            default: begin
                hit  = match;
                last = probe_cnt_reg == lim_m1;
            end
        endcase
    end

    always_comb begin
        res_status = ST_NOT_FOUND;
        res_value  = '0;
        res_extra  = '0;
        res_key    = '0;
        res_hash   = '0;
        res_idx    = '0;
        wr_en      = cmd.clear_wr;
        wr_data    = '0;
        used_next  = used_reg;
        if (cmd.finish_early) begin
            if (cmd_reg == CMD_NEXT) begin
                res_status = ST_END;
                res_idx    = IDXF_W'(SLOTS);
            end
        end else if (cmd.finish_probe) begin
            if (hit) begin
                case (cmd_reg)
                    CMD_NEXT: begin
                        res_status = ST_FOUND;
                        res_hash   = rd_data_reg.hash;
                        res_key    = rd_data_reg.key;
                        res_value  = rd_data_reg.value;
                        res_extra  = rd_data_reg.extra;
                        res_idx    = IDXF_W'(idx_plus1);
                    end
                    CMD_SET: begin
                        wr_en         = 1'b1;
                        wr_data.hash  = hash_reg;
                        wr_data.key   = key_reg;
                        wr_data.value = value_reg;
                        wr_data.extra = extra_reg;
                        res_idx       = IDXF_W'(idx_reg);
                        if (!occupied) begin
                            res_status = ST_ADDED;
                            used_next  = used_reg + 1'b1;
                        end else begin
                            res_status = ST_UPDATED;
                            res_value  = rd_data_reg.value;
                            res_extra  = rd_data_reg.extra;
                        end
                    end
                    CMD_REMOVE: begin
                        wr_en      = 1'b1;
                        res_status = ST_REMOVED;
                        res_idx    = IDXF_W'(idx_reg);
                        if (used_reg != '0) begin
                            used_next = used_reg - 1'b1;
                        end
                    end
                    default: begin
                        res_status = ST_FOUND;
                        res_value  = rd_data_reg.value;
                        res_extra  = rd_data_reg.extra;
                        res_idx    = IDXF_W'(idx_reg);
                    end
                endcase
            end else begin
                case (cmd_reg)
                    CMD_NEXT: begin
                        res_status = ST_END;
                        res_idx    = IDXF_W'(SLOTS);
                    end
                    CMD_SET:  res_status = ST_FULL;
                    default:  res_status = ST_NOT_FOUND;
                endcase
            end
        end
    end

    assign finish = cmd.finish_early || cmd.finish_probe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_status_reg <= res_status;
            m_value_reg  <= res_value;
            m_extra_reg  <= res_extra;
            m_key_reg    <= res_key;
            m_hash_reg   <= res_hash;
            m_idx_reg    <= res_idx;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_value  = m_value_reg;
    assign m_out_extra  = m_extra_reg;
    assign m_out_key    = m_key_reg;
    assign m_out_hash   = m_hash_reg;
    assign m_slot_index = m_idx_reg;

    always_comb begin
        stat.clear_last = idx_reg == LAST_IDX;
        stat.is_next    = cmd_reg == CMD_NEXT;
        stat.start_oob  = start_ext >= CMP_W'(SLOTS);
        stat.hash_zero  = hash_reg == '0;
        stat.mod_done   = mod_done;
        stat.hit        = hit;
        stat.last       = last;
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

// ----- sv/lphm_ctrl.sv -----
module lphm_ctrl import lphm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_SETUP;
            end
            S_SETUP: begin
                if (stat.is_next) begin
                    if (!stat.start_oob) begin
                        state_next = S_CHECK;
                    end else if (stat.out_free) begin
                        state_next = S_IDLE;
                    end
                end else if (!stat.hash_zero) begin
                    state_next = S_HASH;
                end else if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_HASH: begin
                if (stat.mod_done) state_next = S_CHECK;
            end
            S_CHECK: begin
                if ((stat.hit || stat.last) && stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clear_wr = 1'b1;
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_SETUP: begin
                if (stat.is_next) begin
                    cmd.load_start   = !stat.start_oob;
                    cmd.finish_early = stat.start_oob && stat.out_free;
                end else begin
                    cmd.mod_start    = !stat.hash_zero;
                    cmd.finish_early = stat.hash_zero && stat.out_free;
                end
            end
            S_HASH: cmd.load_hash = stat.mod_done;
            S_CHECK: begin
                if (stat.hit || stat.last) begin
                    cmd.finish_probe = stat.out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- sv/linear_probe_hash_map.sv -----
// Channel   Ports     Beat contents
// -------   -------   -------------------------------------------------------
// request   s_*       cmd, key_hash, key_word, new_value, new_extra, start_slot
// result    m_*       status, out_value, out_extra, out_key, out_hash, slot_index
//
// One request at a time; each beat gives exactly one result beat.
// get/set/remove: latch, hash reduction (mask when SLOTS is a power of two,
//   else reciprocal multiplication), then probe slots, at most min(used+1, SLOTS).
// next: scan from start_slot; a start past the table (next) or a zero hash (others) ends early.
// After reset the table is zeroed by a pass over all SLOTS slots with s_ready low.
// A held result stalls completion only; a new request is taken meanwhile.
module linear_probe_hash_map import lphm_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [HASH_W-1:0] s_key_hash,
    input  logic [KEY_W-1:0]  s_key_word,
    input  logic [VAL_W-1:0]  s_new_value,
    input  logic [EXT_W-1:0]  s_new_extra,
    input  logic [IDXF_W-1:0] s_start_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [VAL_W-1:0]  m_out_value,
    output logic [EXT_W-1:0]  m_out_extra,
    output logic [KEY_W-1:0]  m_out_key,
    output logic [HASH_W-1:0] m_out_hash,
    output logic [IDXF_W-1:0] m_slot_index
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    lphm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    lphm_datapath #(.SLOTS(SLOTS)) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .s_cmd        (s_cmd),
        .s_key_hash   (s_key_hash),
        .s_key_word   (s_key_word),
        .s_new_value  (s_new_value),
        .s_new_extra  (s_new_extra),
        .s_start_slot (s_start_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_value  (m_out_value),
        .m_out_extra  (m_out_extra),
        .m_out_key    (m_out_key),
        .m_out_hash   (m_out_hash),
        .m_slot_index (m_slot_index)
    );

endmodule

// ----- sim/linear_probe_hash_map_test.sv -----
`timescale 1ns / 100ps

module linear_probe_hash_map_test;
    import lphm_pkg::*;

    localparam int unsigned NSLOT = SLOTS_DEF;
    localparam int PHASES = 7;
    localparam int PER_PHASE = 200;
    localparam int POOL = 80;
    localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] hash;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] extra;
        logic [6:0]  start;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] value;
        logic [31:0] extra;
        logic [63:0] key;
        logic [31:0] hash;
        logic [6:0]  index;
    } outcome_t;

    typedef struct {
        request_t rq;
        bit       fixed;
        outcome_t want;
    } stim_row_t;

    typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} op_mix_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd = '0;
    logic [HASH_W-1:0] s_key_hash = '0;
    logic [KEY_W-1:0]  s_key_word = '0;
    logic [VAL_W-1:0]  s_new_value = '0;
    logic [EXT_W-1:0]  s_new_extra = '0;
    logic [IDXF_W-1:0] s_start_slot = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [VAL_W-1:0]  m_out_value;
    logic [EXT_W-1:0]  m_out_extra;
    logic [KEY_W-1:0]  m_out_key;
    logic [HASH_W-1:0] m_out_hash;
    logic [IDXF_W-1:0] m_slot_index;

    // mirror of the table contents
    logic [31:0] map_hash  [NSLOT];
    logic [63:0] map_key   [NSLOT];
    logic [63:0] map_value [NSLOT];
    logic [31:0] map_extra [NSLOT];
    int unsigned map_count;

    logic [31:0] pool_hash [POOL];
    logic [63:0] pool_key  [POOL];

    stim_row_t stim_rows[$];
    outcome_t  pending_results[$];
    int        mismatches = 0;
    logic      quiet = 1'b0;

    linear_probe_hash_map #(.SLOTS(NSLOT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_key_hash(s_key_hash), .s_key_word(s_key_word),
        .s_new_value(s_new_value), .s_new_extra(s_new_extra),
        .s_start_slot(s_start_slot),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_out_value(m_out_value), .m_out_extra(m_out_extra),
        .m_out_key(m_out_key), .m_out_hash(m_out_hash), .m_slot_index(m_slot_index)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Applies one request to the mirror and returns the result it must give.
    function automatic outcome_t apply_to_mirror(input request_t rq);
        outcome_t    o;
        int unsigned pos;
        int unsigned lim;
        bit          done;
        o = '0;
        o.status = ST_NOT_FOUND;
        done = 1'b0;
        pos = rq.hash % NSLOT;
        lim = (map_count + 1 > NSLOT) ? NSLOT : map_count + 1;
        if (rq.cmd == CMD_NEXT) begin
            o.status = ST_END;
            o.index = IDXF_W'(NSLOT);
            for (int unsigned i = rq.start; i < NSLOT && !done; i++) begin
                if (map_hash[i] != 0) begin
                    o.status = ST_FOUND;
                    o.hash = map_hash[i];
                    o.key = map_key[i];
                    o.value = map_value[i];
                    o.extra = map_extra[i];
                    o.index = IDXF_W'(i + 1);
                    done = 1'b1;
                end
            end
        end else if (rq.hash == 0) begin
            o.status = ST_NOT_FOUND;
        end else if (rq.cmd == CMD_SET) begin
            o.status = ST_FULL;
            for (int unsigned i = 0; i < lim && !done; i++) begin
                if (map_hash[pos] == 0) begin
                    map_hash[pos] = rq.hash;
                    map_key[pos] = rq.key;
                    map_value[pos] = rq.value;
                    map_extra[pos] = rq.extra;
                    map_count++;
                    o.status = ST_ADDED;
                    o.index = IDXF_W'(pos);
                    done = 1'b1;
                end else if (map_hash[pos] == rq.hash && map_key[pos] == rq.key) begin
                    o.value = map_value[pos];
                    o.extra = map_extra[pos];
                    map_value[pos] = rq.value;
                    map_extra[pos] = rq.extra;
                    o.status = ST_UPDATED;
                    o.index = IDXF_W'(pos);
                    done = 1'b1;
                end else begin
                    pos = (pos + 1) % NSLOT;
                end
            end
        end else begin
            // get and remove skip over empty slots
            for (int unsigned i = 0; i < lim && !done; i++) begin
                if (map_hash[pos] == rq.hash && map_key[pos] == rq.key) begin
                    done = 1'b1;
                    o.index = IDXF_W'(pos);
                    if (rq.cmd == CMD_GET) begin
                        o.status = ST_FOUND;
                        o.value = map_value[pos];
                        o.extra = map_extra[pos];
                    end else begin
                        o.status = ST_REMOVED;
                        map_hash[pos] = '0;
                        map_key[pos] = '0;
                        map_value[pos] = '0;
                        map_extra[pos] = '0;
                        if (map_count > 0) map_count--;
                    end
                end else begin
                    pos = (pos + 1) % NSLOT;
                end
            end
        end
        return o;
    endfunction

    function automatic request_t random_request(input op_mix_t mix);
        request_t    rq;
        int unsigned pick;
        int unsigned roll;
        pick = $urandom_range(0, POOL - 1);
        rq.hash = pool_hash[pick];
        rq.key = pool_key[pick];
        rq.value = {$urandom, $urandom};
        rq.extra = $urandom;
        rq.start = 7'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 63)
                                                    : $urandom_range(64, 127));
        roll = $urandom_range(0, 99);
        rq.cmd = CMD_NEXT;
        case (mix)
            FILL_OPS: begin
                if (roll < 70) rq.cmd = CMD_SET;
                else if (roll < 85) rq.cmd = CMD_GET;
                else if (roll < 92) rq.cmd = CMD_REMOVE;
            end
            DRAIN_OPS: begin
                if (roll < 60) rq.cmd = CMD_REMOVE;
                else if (roll < 80) rq.cmd = CMD_GET;
                else if (roll < 90) rq.cmd = CMD_SET;
            end
            default: begin
                if (roll < 35) rq.cmd = CMD_GET;
                else if (roll < 70) rq.cmd = CMD_SET;
                else if (roll < 90) rq.cmd = CMD_REMOVE;
            end
        endcase
        // noise: stray commands, stray keys, stray hashes, the reserved hash
        if ($urandom_range(0, 99) < 8) begin
            rq.cmd = cmd_t'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
                rq.key = {$urandom, $urandom};
            else
                rq.hash = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
        end
        return rq;
    endfunction

    task automatic add_row(input cmd_t c, input logic [31:0] h, input logic [63:0] k,
                           input logic [63:0] v, input logic [31:0] e, input logic [6:0] st);
        stim_row_t row;
        row.rq = '{cmd: c, hash: h, key: k, value: v, extra: e, start: st};
        row.fixed = 1'b0;
        row.want = '0;
        stim_rows.push_back(row);
    endtask

    // row whose result is plain: only status and index can be nonzero
    task automatic add_fixed(input cmd_t c, input logic [31:0] h, input logic [63:0] k,
                             input logic [6:0] st, input status_t ws, input logic [6:0] wi);
        add_row(c, h, k, '1, '1, st);
        stim_rows[$].fixed = 1'b1;
        stim_rows[$].want.status = ws;
        stim_rows[$].want.index = wi;
    endtask

    task automatic send_request(input request_t rq, input bit fixed, input outcome_t want);
        outcome_t predicted;
        s_valid <= 1'b1;
        s_cmd <= rq.cmd;
        s_key_hash <= rq.hash;
        s_key_word <= rq.key;
        s_new_value <= rq.value;
        s_new_extra <= rq.extra;
        s_start_slot <= rq.start;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_to_mirror(rq);
        pending_results.push_back(fixed ? want : predicted);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 30);
        end
    endtask

    initial begin
        logic [31:0] tmp;
        op_mix_t     mix;
        for (int i = 0; i < NSLOT; i++) begin
            map_hash[i] = '0;
            map_key[i] = '0;
            map_value[i] = '0;
            map_extra[i] = '0;
        end
        map_count = 0;

        // key pool with shared home slots and shared hashes
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = {$urandom, $urandom};
            tmp = $urandom;
            case (i % 5)
                1: pool_hash[i] = {tmp[31:6], pool_hash[i-1][5:0]};
                2: pool_hash[i] = pool_hash[i-1];
                default: pool_hash[i] = tmp;
            endcase
            if (pool_hash[i] == 0) pool_hash[i] = 32'h40;
        end

        add_fixed(CMD_GET,    32'd5,   64'd1, 7'd0,   ST_NOT_FOUND, 7'd0);
        add_fixed(CMD_NEXT,   32'd0,   64'd0, 7'd0,   ST_END,       7'd64);
        add_fixed(CMD_SET,    32'd0,   KEY_A, 7'd0,   ST_NOT_FOUND, 7'd0);
        add_row(CMD_SET,    32'd1,        KEY_A, '1, '1, 7'd0);
        add_row(CMD_SET,    32'd65,       KEY_B, 64'h5555_AAAA_5555_AAAA, 32'hA5A5_5A5A, 7'd0);
        add_row(CMD_SET,    32'd1,        KEY_A, '0, '0, 7'd0);
        add_row(CMD_GET,    32'd65,       KEY_B, '0, '0, 7'd0);
        add_row(CMD_GET,    32'd1,        KEY_B, '0, '0, 7'd0);
        add_fixed(CMD_GET,    32'd0,   KEY_A, 7'd0,   ST_NOT_FOUND, 7'd0);
        add_fixed(CMD_REMOVE, 32'd0,   KEY_A, 7'd0,   ST_NOT_FOUND, 7'd0);
        add_row(CMD_REMOVE, 32'd1,        KEY_A, '0, '0, 7'd0);
        add_row(CMD_GET,    32'd65,       KEY_B, '0, '0, 7'd0);
        add_row(CMD_REMOVE, 32'd1,        KEY_A, '0, '0, 7'd0);
        add_row(CMD_SET,    32'hFFFF_FFFF, '1,   '1, '1, 7'd0);
        add_row(CMD_SET,    32'h0000_007F, '0,   '0, '0, 7'd0);
        add_row(CMD_NEXT,   32'd0,        '0,    '0, '0, 7'd0);
        add_row(CMD_NEXT,   32'd0,        '0,    '0, '0, 7'd1);
        add_row(CMD_NEXT,   32'hFFFF_FFFF, '1,   '1, '1, 7'd63);
        add_fixed(CMD_NEXT,   32'd0,   64'd0, 7'd64,  ST_END,       7'd64);
        add_fixed(CMD_NEXT,   32'd0,   64'd0, 7'd127, ST_END,       7'd64);
        add_row(CMD_GET,    32'hFFFF_FFFF, '1,   '0, '0, 7'd0);
        add_row(CMD_REMOVE, 32'd65,       KEY_B, '0, '0, 7'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i])
            send_request(stim_rows[i].rq, stim_rows[i].fixed, stim_rows[i].want);

        // drain completely before the random part
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            quiet <= (ph == 2);
            case (ph % 4)
                1: mix = FILL_OPS;
                3: mix = DRAIN_OPS;
                default: mix = MIX_OPS;
            endcase
            for (int n = 0; n < PER_PHASE; n++)
                send_request(random_request(mix), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        m_ready <= quiet || ($urandom_range(0, 99) >= 9);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, status %0d", $time, m_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_status);
                    mismatches++;
                end
                if (m_out_value !== want.value) begin
                    $display("%0t: out_value expected %h got %h", $time, want.value, m_out_value);
                    mismatches++;
                end
                if (m_out_extra !== want.extra) begin
                    $display("%0t: out_extra expected %h got %h", $time, want.extra, m_out_extra);
                    mismatches++;
                end
                if (m_out_key !== want.key) begin
                    $display("%0t: out_key expected %h got %h", $time, want.key, m_out_key);
                    mismatches++;
                end
                if (m_out_hash !== want.hash) begin
                    $display("%0t: out_hash expected %h got %h", $time, want.hash, m_out_hash);
                    mismatches++;
                end
                if (m_slot_index !== want.index) begin
                    $display("%0t: slot_index expected %0d got %0d", $time, want.index,
                             m_slot_index);
                    mismatches++;
                end
            end
        end
    end

endmodule
